[hw/rtl/hafp_pkg.sv]
// shared constants and elaboration-time angle table function for the heading block
`timescale 1ns / 1ps

package hafp_pkg;

  // angles are carried as degrees with this many fraction bits
  localparam int unsigned ANG_INT_FRAC = 24;
  // signed angle accumulator width, covers -190 .. +280 degrees
  localparam int unsigned ANG_W = ANG_INT_FRAC + 10;
  // difference vector is scaled up by 2^VEC_SHIFT before the rotations
  localparam int unsigned VEC_SHIFT = 16;
  // 180 / pi with 24 fraction bits
  localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

  localparam logic [63:0] DEG_45  = 64'd45;
  localparam logic [63:0] DEG_90  = 64'd90;
  localparam logic [63:0] DEG_180 = 64'd180;
  localparam logic [63:0] DEG_270 = 64'd270;
  localparam logic [63:0] DEG_360 = 64'd360;

  // restoring long division, used only for constant tables
  function automatic logic [63:0] div_const(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest
  function automatic logic [63:0] atan_deg_q24(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] rad32;
    logic        neg;
    int unsigned k;
    acc = '0;
    neg = 1'b0;
    k   = 1;
    if (i == 0) begin
      return DEG_45 << ANG_INT_FRAC;
    end
    while (i * k <= 62) begin
      term = div_const(64'd1 << (62 - i * k), 64'(k));
      acc  = neg ? acc - term : acc + term;
      neg  = !neg;
      k    = k + 2;
    end
    rad32 = (acc + (64'd1 << 29)) >> 30;
    return (rad32 * DEG_PER_RAD_Q24 + (64'd1 << 31)) >> 32;
  endfunction

endpackage

[hw/rtl/heading_angle_from_points.sv]
// heading from two points: pipelined cordic vectoring atan2 in degrees
`timescale 1ns / 1ps
// throughput: one beat per cycle while the output is not stalled; one register stage per
//   cordic rotation, plus a difference stage, a half-plane fold stage, a wrap stage and a
//   rounding stage
// each stage has its own valid bit and holds only when it is full and the next one holds,
//   so bubbles collapse; intake stops only when all stages are full behind a stalled output
// reset: asynchronous active low, clears all valid bits; payload registers are not reset

module heading_angle_from_points
  import hafp_pkg::*;
#(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 8,
  parameter int unsigned CORDIC_STAGES   = 18
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic signed [COORD_WIDTH-1:0]    from_x_i,
  input  logic signed [COORD_WIDTH-1:0]    from_y_i,
  input  logic signed [COORD_WIDTH-1:0]    to_x_i,
  input  logic signed [COORD_WIDTH-1:0]    to_y_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic [9+ANGLE_FRAC_BITS-1:0]     heading_o
);

  // exact difference width
  localparam int unsigned DIFF_W = COORD_WIDTH + 1;
  // x/y width: scaled vector plus headroom for cordic gain
  localparam int unsigned XY_W   = DIFF_W + VEC_SHIFT + 3;
  localparam int unsigned HEAD_W = 9 + ANGLE_FRAC_BITS;
  // right shift from internal angle to output angle
  localparam int unsigned SH     = ANG_INT_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ANG_W-1:0] Z_90  = ANG_W'(DEG_90 << ANG_INT_FRAC);
  localparam logic signed [ANG_W-1:0] Z_180 = ANG_W'(DEG_180 << ANG_INT_FRAC);
  localparam logic signed [ANG_W-1:0] Z_360 = ANG_W'(DEG_360 << ANG_INT_FRAC);
  localparam logic [ANG_W-1:0]        HALF  = ANG_W'(64'd1 << (SH - 1));
  localparam logic [HEAD_W-1:0]       FULL_OUT = HEAD_W'(DEG_360 << ANGLE_FRAC_BITS);
  localparam logic [HEAD_W-1:0]       HEAD_270 = HEAD_W'(DEG_270 << ANGLE_FRAC_BITS);

  // per-stage enables: a stage may load when empty or when its successor loads
  logic                     en_p0;
  logic                     en_c [CORDIC_STAGES+1];
  logic                     en_h;
  logic                     en_out;

  // difference stage
  logic                     v0_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic                     zero0_q;

  // cordic stages: entry 0 after the half-plane fold, entry i+1 after rotation i
  logic                     cv_q    [CORDIC_STAGES+1];
  logic                     czero_q [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]   cx_q    [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]   cy_q    [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]  cz_q    [CORDIC_STAGES+1];

  // wrap stage
  logic                     hv_q;
  logic                     hzero_q;
  logic [ANG_W-1:0]         h_q;

  // output stage
  logic                     ov_q;
  logic [HEAD_W-1:0]        heading_q;

  always_comb begin
    en_out = !ov_q || !stall_i;
    en_h   = !hv_q || en_out;
    en_c[CORDIC_STAGES] = !cv_q[CORDIC_STAGES] || en_h;
    for (int i = CORDIC_STAGES - 1; i >= 0; i--) begin
      en_c[i] = !cv_q[i] || en_c[i+1];
    end
    en_p0 = !v0_q || en_c[0];
  end

  assign stall_o = !en_p0;

  // ---------------------------------------------------------------- difference
  logic signed [DIFF_W-1:0] dx_d, dy_d;

  assign dx_d = DIFF_W'(to_x_i) - DIFF_W'(from_x_i);
  assign dy_d = DIFF_W'(to_y_i) - DIFF_W'(from_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_p0) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p0) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      zero0_q <= (dx_d == '0) && (dy_d == '0);
    end
  end

  // ---------------------------------------------------------------- half-plane fold
  // a vector in the left half-plane is negated and starts at 180 degrees
  logic                     fold;
  logic signed [DIFF_W-1:0] fx, fy;

  assign fold = dx_q < 0;
  assign fx   = fold ? -dx_q : dx_q;
  assign fy   = fold ? -dy_q : dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en_c[0]) begin
      cv_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c[0]) begin
      cx_q[0]    <= XY_W'(fx) <<< VEC_SHIFT;
      cy_q[0]    <= XY_W'(fy) <<< VEC_SHIFT;
      cz_q[0]    <= fold ? Z_180 : '0;
      czero_q[0] <= zero0_q;
    end
  end

  // ---------------------------------------------------------------- rotations
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    localparam logic signed [ANG_W-1:0] ANG = ANG_W'(atan_deg_q24(g));

    logic signed [XY_W-1:0] xs, ys;
    logic                   up;

    assign xs = cx_q[g] >>> g;
    assign ys = cy_q[g] >>> g;
    // rotate toward the x axis
    assign up = cy_q[g] > 0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[g+1] <= 1'b0;
      end else if (en_c[g+1]) begin
        cv_q[g+1] <= cv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_c[g+1]) begin
        cx_q[g+1]    <= up ? cx_q[g] + ys : cx_q[g] - ys;
        cy_q[g+1]    <= up ? cy_q[g] - xs : cy_q[g] + xs;
        cz_q[g+1]    <= up ? cz_q[g] + ANG : cz_q[g] - ANG;
        czero_q[g+1] <= czero_q[g];
      end
    end
  end

  // ---------------------------------------------------------------- turn by -90 and wrap
  logic signed [ANG_W-1:0] h_raw;
  logic signed [ANG_W-1:0] h_wrap;

  assign h_raw  = cz_q[CORDIC_STAGES] - Z_90;
  assign h_wrap = (h_raw < 0) ? h_raw + Z_360 : h_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
    end else if (en_h) begin
      hv_q <= cv_q[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_h) begin
      h_q     <= h_wrap;
      hzero_q <= czero_q[CORDIC_STAGES];
    end
  end

  // ---------------------------------------------------------------- round to output
  logic [ANG_W-1:0]  r_sum;
  logic [ANG_W-1:0]  r_shift;
  logic [HEAD_W-1:0] r_round;
  logic [HEAD_W-1:0] heading_d;

  always_comb begin
    r_sum   = h_q + HALF;
    r_shift = r_sum >> SH;
    r_round = r_shift[HEAD_W-1:0];
    // a rounded 360 wraps to 0
    if (r_round >= FULL_OUT) begin
      r_round = r_round - FULL_OUT;
    end
    // coinciding points
    heading_d = hzero_q ? HEAD_270 : r_round;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_out) begin
      ov_q <= hv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = ov_q;
  assign heading_o = heading_q;

endmodule
